// ===== rtl/dra_pkg.sv =====
// Shared types and constants for the DNS response address parser.
// No dependencies; imported by dra_parser and dns_response_address_parser.
package dra_pkg;

  // Status codes reported with each result
  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_NOT_RESPONSE = 3'd1;
  localparam logic [2:0] STATUS_RCODE_ERROR  = 3'd2;
  localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_NO_A_RECORD  = 3'd4;

  // Configuration register map
  localparam int          PADDR_W          = 2;
  localparam logic [PADDR_W-1:0] REG_EXPECTED_ID = 2'd0;
  localparam logic [15:0] EXPECTED_ID_RESET = 16'd6828;

  // DNS constants
  localparam logic [7:0]  MAX_LABEL_LEN = 8'd63;
  localparam logic [15:0] TYPE_A        = 16'd1;
  localparam logic [15:0] A_RDLENGTH    = 16'd4;

  typedef struct packed {
    logic [3:0]  rcode;
    logic        id_mismatch;
    logic [2:0]  status;
    logic [31:0] address;
  } result_t;

endpackage

// ===== rtl/dra_parser.sv =====
// Byte-wise DNS response parser: holds the parse state and forms the result
// for the byte being taken. Depends on dra_pkg.
module dra_parser #(
  parameter int MAX_MSG_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       msg_byte,
  input  logic             last,
  input  logic [15:0]      expected_id,
  output dra_pkg::result_t result
);
  import dra_pkg::*;

  localparam int CW = $clog2(MAX_MSG_BYTES + 2);

  typedef enum logic [3:0] {
    PH_HDR, PH_QNAME, PH_QTAIL, PH_ASTART, PH_ANAME, PH_APTR,
    PH_AFIX, PH_ARDATA, PH_SKIP, PH_DONE, PH_OVER
  } phase_t;

  logic [CW-1:0] byte_count, byte_count_next;
  phase_t        phase, phase_next;
  logic [3:0]    field_index, field_index_next;
  logic [15:0]   header_id, header_id_next;
  logic [15:0]   flags_word, flags_word_next;
  logic [15:0]   questions_left, questions_left_next;
  logic [15:0]   answers_left, answers_left_next;
  logic [7:0]    label_left, label_left_next;
  logic [15:0]   record_type, record_type_next;
  logic [15:0]   data_left, data_left_next;
  logic [31:0]   addr_accum, addr_accum_next;
  logic          found_a, found_a_next;
  logic          parse_done, parse_done_next;

  always_comb begin
    byte_count_next     = byte_count;
    phase_next          = phase;
    field_index_next    = field_index;
    header_id_next      = header_id;
    flags_word_next     = flags_word;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    label_left_next     = label_left;
    record_type_next    = record_type;
    data_left_next      = data_left;
    addr_accum_next     = addr_accum;
    found_a_next        = found_a;
    parse_done_next     = parse_done;

    // saturate one past the limit
    if (byte_count <= CW'(MAX_MSG_BYTES)) byte_count_next = byte_count + 1'b1;

    case (phase)
      PH_HDR: begin
        if (field_index < 4'd2) header_id_next = {header_id[7:0], msg_byte};
        else if (field_index < 4'd4) flags_word_next = {flags_word[7:0], msg_byte};
        else if (field_index < 4'd6) questions_left_next = {questions_left[7:0], msg_byte};
        else if (field_index < 4'd8) answers_left_next = {answers_left[7:0], msg_byte};
        if (field_index >= 4'd11) begin
          field_index_next = '0;
          if (questions_left != '0) begin
            phase_next      = PH_QNAME;
            label_left_next = '0;
          end else if (answers_left != '0) begin
            phase_next = PH_ASTART;
          end else begin
            phase_next      = PH_DONE;
            parse_done_next = 1'b1;
          end
        end else begin
          field_index_next = field_index + 1'b1;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (label_left != '0) begin
          label_left_next = label_left - 1'b1;
        end else if (msg_byte == '0) begin
          field_index_next = '0;
          phase_next       = (phase == PH_QNAME) ? PH_QTAIL : PH_AFIX;
        end else begin
          label_left_next = msg_byte;
        end
      end
      PH_QTAIL: begin
        if (field_index >= 4'd3) begin
          field_index_next    = '0;
          questions_left_next = questions_left - 1'b1;
          if (questions_left_next != '0) begin
            phase_next      = PH_QNAME;
            label_left_next = '0;
          end else if (answers_left != '0) begin
            phase_next = PH_ASTART;
          end else begin
            phase_next      = PH_DONE;
            parse_done_next = 1'b1;
          end
        end else begin
          field_index_next = field_index + 1'b1;
        end
      end
      PH_ASTART: begin
        field_index_next = '0;
        if (msg_byte > MAX_LABEL_LEN) begin
          phase_next = PH_APTR;
        end else if (msg_byte == '0) begin
          phase_next = PH_AFIX;
        end else begin
          label_left_next = msg_byte;
          phase_next      = PH_ANAME;
        end
      end
      PH_APTR: begin
        field_index_next = '0;
        phase_next       = PH_AFIX;
      end
      PH_AFIX: begin
        if (field_index < 4'd2) record_type_next = {record_type[7:0], msg_byte};
        else if (field_index >= 4'd8) data_left_next = {data_left[7:0], msg_byte};
        if (field_index >= 4'd9) begin
          field_index_next = '0;
          if (record_type_next == TYPE_A && data_left_next == A_RDLENGTH) begin
            phase_next = PH_ARDATA;
          end else if (data_left_next == '0) begin
            answers_left_next = answers_left - 1'b1;
            if (answers_left_next != '0) begin
              phase_next = PH_ASTART;
            end else begin
              phase_next      = PH_DONE;
              parse_done_next = 1'b1;
            end
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          field_index_next = field_index + 1'b1;
        end
      end
      PH_ARDATA: begin
        addr_accum_next = {addr_accum[23:0], msg_byte};
        if (field_index >= 4'd3) begin
          field_index_next  = '0;
          found_a_next      = 1'b1;
          answers_left_next = answers_left - 1'b1;
          if (answers_left_next != '0) begin
            phase_next = PH_ASTART;
          end else begin
            phase_next      = PH_DONE;
            parse_done_next = 1'b1;
          end
        end else begin
          field_index_next = field_index + 1'b1;
        end
      end
      PH_SKIP: begin
        data_left_next = data_left - 1'b1;
        if (data_left_next == '0) begin
          answers_left_next = answers_left - 1'b1;
          if (answers_left_next != '0) begin
            phase_next = PH_ASTART;
          end else begin
            phase_next      = PH_DONE;
            parse_done_next = 1'b1;
          end
        end
      end
      default: begin
        // any byte past the answers
        phase_next      = PH_OVER;
        parse_done_next = 1'b0;
      end
    endcase
  end

  // result as seen after this byte
  always_comb begin
    result.address     = addr_accum_next;
    result.rcode       = flags_word_next[3:0];
    result.id_mismatch = (byte_count_next >= CW'(2)) && (header_id_next != expected_id);
    if (byte_count_next < CW'(4)) begin
      result.status = STATUS_LEN_MISMATCH;
    end else if (!flags_word_next[15]) begin
      result.status = STATUS_NOT_RESPONSE;
    end else if (flags_word_next[3:0] != 4'd0) begin
      result.status = STATUS_RCODE_ERROR;
    end else if (!parse_done_next || byte_count_next > CW'(MAX_MSG_BYTES)) begin
      result.status = STATUS_LEN_MISMATCH;
    end else if (!found_a_next) begin
      result.status = STATUS_NO_A_RECORD;
    end else begin
      result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      byte_count     <= '0;
      phase          <= PH_HDR;
      field_index    <= '0;
      header_id      <= '0;
      flags_word     <= '0;
      questions_left <= '0;
      answers_left   <= '0;
      label_left     <= '0;
      record_type    <= '0;
      data_left      <= '0;
      addr_accum     <= '0;
      found_a        <= 1'b0;
      parse_done     <= 1'b0;
    end else if (take) begin
      byte_count     <= byte_count_next;
      phase          <= phase_next;
      field_index    <= field_index_next;
      header_id      <= header_id_next;
      flags_word     <= flags_word_next;
      questions_left <= questions_left_next;
      answers_left   <= answers_left_next;
      label_left     <= label_left_next;
      record_type    <= record_type_next;
      data_left      <= data_left_next;
      addr_accum     <= addr_accum_next;
      found_a        <= found_a_next;
      parse_done     <= parse_done_next;
    end
  end

endmodule

// ===== rtl/dns_response_address_parser.sv =====
// DNS response address parser: one message byte per item in, one result per message.
// The result item is registered: valid in the cycle after the tlast item is taken.
// Throughput: one byte per cycle while the output register is empty or draining; the
// parse step lies between the state and output registers, so bytes need no gaps.
// Reset (rst, synchronous): clears the parse state and the output valid flag,
// and sets expected_id to 6828. Depends on dra_pkg and dra_parser.
module dns_response_address_parser #(
  parameter int MAX_MSG_BYTES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dra_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // message bytes in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] msg_byte
  input  logic                        s_tlast,   // last byte of the message
  // results out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata    // [31:0] address, [34:32] status,
                                                 // [35] id_mismatch, [39:36] rcode
);
  import dra_pkg::*;

  logic [15:0] expected_id;
  logic        take;
  result_t     step_result;
  result_t     out_result;

  // Configuration: writes land on the access phase; pready is tied high.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= EXPECTED_ID_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_EXPECTED_ID)) begin
      expected_id <= pwdata[15:0];
    end
  end

  always_comb begin
    case (paddr)
      REG_EXPECTED_ID: prdata = {16'd0, expected_id};
      default:         prdata = '0;
    endcase
  end

  // Take a byte whenever the output register is empty or drains this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  dra_parser #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .msg_byte    (s_tdata),
    .last        (s_tlast),
    .expected_id (expected_id),
    .result      (step_result)
  );

  // Output register: load on the last byte, drop when the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {out_result.rcode, out_result.id_mismatch,
                    out_result.status, out_result.address};

endmodule
